>>> src/pcs_pkg.sv
package pcs_pkg;

  localparam int POS_W      = 24;
  localparam int KIND_W     = 2;
  localparam int CFG_W      = 24;
  localparam int IDX_OUT_W  = 10;
  localparam int END_OUT_W  = 11;
  localparam int IN_DATA_W  = 2 * POS_W;
  localparam int IN_USER_W  = KIND_W;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 1;

  localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic CFG_IDX_CORRIDOR = 1'b0;
  localparam logic CFG_IDX_SEARCH   = 1'b1;

  localparam logic [CFG_W-1:0] RST_CORRIDOR_MM = 24'd1250;
  localparam logic [CFG_W-1:0] RST_SEARCH_MM   = 24'd2000;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

>>> src/pcs_ram.sv
module pcs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> src/pcs_dist.sv
module pcs_dist #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic                         done_o,
  output logic [COORD_BITS:0]          dist_o
);

  localparam int R_W   = COORD_BITS + 1;
  localparam int RAD_W = 2 * R_W;
  localparam int CNT_W = $clog2(R_W + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SQ   = 2'd1;
  localparam logic [1:0] PH_SUM  = 2'd2;
  localparam logic [1:0] PH_ROOT = 2'd3;

  logic [1:0]              ph_q;
  logic [COORD_BITS-1:0]   dx_q, dy_q;
  logic [2*COORD_BITS-1:0] sqx_q, sqy_q;
  logic [RAD_W-1:0]        rad_q;
  logic [R_W+1:0]          rem_q;
  logic [R_W-1:0]          root_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    done_q;

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [R_W+3:0]             rem_sh;
  logic [R_W+3:0]             trial;
  logic                       take;

  always_comb begin
    diff_x = (COORD_BITS+1)'(ax_i) - (COORD_BITS+1)'(bx_i);
    diff_y = (COORD_BITS+1)'(ay_i) - (COORD_BITS+1)'(by_i);
    rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
    trial  = (R_W+4)'({root_q, 2'b01});
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      done_q <= 1'b0;
      dx_q   <= '0;
      dy_q   <= '0;
      sqx_q  <= '0;
      sqy_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (ph_q)
        PH_IDLE: begin
          if (go_i) begin
            dx_q <= diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : COORD_BITS'(diff_x);
            dy_q <= diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : COORD_BITS'(diff_y);
            ph_q <= PH_SQ;
          end
        end
        PH_SQ: begin
          sqx_q <= dx_q * dx_q;
          sqy_q <= dy_q * dy_q;
          ph_q  <= PH_SUM;
        end
        PH_SUM: begin
          rad_q  <= RAD_W'(sqx_q) + RAD_W'(sqy_q);
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= CNT_W'(R_W - 1);
          ph_q   <= PH_ROOT;
        end
        PH_ROOT: begin
          // one result bit a cycle, restoring
          rad_q <= rad_q << 2;
          if (take) begin
            rem_q  <= (R_W+2)'(rem_sh - trial);
            root_q <= {root_q[R_W-2:0], 1'b1};
          end else begin
            rem_q  <= (R_W+2)'(rem_sh);
            root_q <= {root_q[R_W-2:0], 1'b0};
          end
          if (cnt_q == '0) begin
            done_q <= 1'b1;
            ph_q   <= PH_IDLE;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign dist_o = root_q;

endmodule

>>> src/path_progress_corridor_search_unit.sv
// point word: taken at its accepting edge; empty-path pose query: goes to S_OUT, then the word is registered
// a query's time is set by the single bit-serial distance unit: two distances per
// window point, one per corridor point, plus a memory check state and a read state
// per point; one item in flight at a time
// reset: empty path, progress index zero, corridor 1250 mm, search 2000 mm
// waypoint memory is not cleared; only entries below the point count are used
module path_progress_corridor_search_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [pcs_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pcs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // pos_x, pos_y
  input  logic [pcs_pkg::IN_USER_W-1:0]    s_axis_tuser,  // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // nearest_index, corridor_limit, overflowed
  output logic [pcs_pkg::OUT_USER_W-1:0]   m_axis_tuser   // status
);
  import pcs_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int R_W   = COORD_BITS + 1;
  localparam int ACC_W = R_W + CFG_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_W_PREV = 4'd1;
  localparam logic [3:0] S_W_Q0   = 4'd2;
  localparam logic [3:0] S_W_CHK  = 4'd3;
  localparam logic [3:0] S_W_RD   = 4'd4;
  localparam logic [3:0] S_W_SEG  = 4'd5;
  localparam logic [3:0] S_W_QD   = 4'd6;
  localparam logic [3:0] S_C_PREV = 4'd7;
  localparam logic [3:0] S_C_CHK  = 4'd8;
  localparam logic [3:0] S_C_RD   = 4'd9;
  localparam logic [3:0] S_C_SEG  = 4'd10;
  localparam logic [3:0] S_OUT    = 4'd11;

  logic [3:0]             state_q;
  logic [CNT_W-1:0]       count_q, end_q;
  logic [IDX_W-1:0]       prog_q, best_q;
  logic                   ovf_q;
  logic [CFG_W-1:0]       corr_q, search_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
  logic                   go_q;
  logic [ACC_W-1:0]       acc_q;
  logic [R_W-1:0]         bestd_q;
  logic                   res_status_q;
  logic [END_OUT_W-1:0]   res_end_q;
  logic                   m_valid_q;
  logic [OUT_DATA_W-1:0]  m_data_q;
  logic [OUT_USER_W-1:0]  m_user_q;

  logic signed [POS_W-1:0]      in_x, in_y;
  logic signed [COORD_BITS-1:0] px, py, rd_x, rd_y;
  logic [2*COORD_BITS-1:0]      rd_data;
  logic                         s_fire, mem_we, mem_re, d_done, more_w, more_c, empty;
  logic [IDX_W-1:0]             mem_waddr, mem_raddr;
  logic [R_W-1:0]               d_res;

  assign in_x = s_axis_tdata[POS_W-1:0];
  assign in_y = s_axis_tdata[2*POS_W-1:POS_W];
  assign px   = COORD_BITS'(in_x);
  assign py   = COORD_BITS'(in_y);
  assign rd_x = rd_data[COORD_BITS-1:0];
  assign rd_y = rd_data[2*COORD_BITS-1:COORD_BITS];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign empty  = (count_q == '0) || (CNT_W'(prog_q) >= count_q);
  assign more_w = (end_q < count_q) && (acc_q < ACC_W'(search_q));
  assign more_c = (end_q < count_q) && (acc_q < ACC_W'(corr_q));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_q[IDX_W-1:0];
    if (s_fire && s_axis_tuser == KIND_NEW) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
    end else if (s_fire && s_axis_tuser == KIND_APPEND &&
                 count_q < CNT_W'(MAX_POINTS)) begin
      mem_we = 1'b1;
    end
    mem_re    = 1'b0;
    mem_raddr = prog_q;
    unique case (state_q)
      S_IDLE:  mem_re = s_fire;
      S_W_CHK: begin
        mem_re    = 1'b1;
        mem_raddr = more_w ? end_q[IDX_W-1:0] : best_q;
      end
      S_C_CHK: begin
        mem_re    = more_c;
        mem_raddr = end_q[IDX_W-1:0];
      end
      default: mem_re = 1'b0;
    endcase
  end

  pcs_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i ({py, px}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  pcs_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go_q),
    .ax_i   (ax_q),
    .ay_i   (ay_q),
    .bx_i   (bx_q),
    .by_i   (by_q),
    .done_o (d_done),
    .dist_o (d_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      prog_q       <= '0;
      ovf_q        <= 1'b0;
      corr_q       <= RST_CORRIDOR_MM;
      search_q     <= RST_SEARCH_MM;
      qx_q         <= '0;
      qy_q         <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      ax_q         <= '0;
      ay_q         <= '0;
      bx_q         <= '0;
      by_q         <= '0;
      go_q         <= 1'b0;
      end_q        <= '0;
      acc_q        <= '0;
      best_q       <= '0;
      bestd_q      <= '0;
      res_status_q <= STATUS_OK;
      res_end_q    <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= '0;
    end else begin
      go_q <= 1'b0;
      if (m_valid_q && m_axis_tready && state_q != S_OUT) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_IDX_CORRIDOR) begin
          corr_q <= cfg_data_i;
        end else begin
          search_q <= cfg_data_i;
        end
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_fire) begin
            case (s_axis_tuser)
              KIND_NEW: begin
                count_q <= CNT_W'(1);
                prog_q  <= '0;
                ovf_q   <= 1'b0;
              end
              KIND_APPEND: begin
                if (count_q < CNT_W'(MAX_POINTS)) begin
                  count_q <= count_q + 1'b1;
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              KIND_QUERY: begin
                qx_q <= px;
                qy_q <= py;
                if (empty) begin
                  res_status_q <= STATUS_EMPTY;
                  best_q       <= '0;
                  res_end_q    <= '0;
                  state_q      <= S_OUT;
                end else begin
                  state_q <= S_W_PREV;
                end
              end
              default: ;
            endcase
          end
        end
        S_W_PREV: begin
          prev_x_q <= rd_x;
          prev_y_q <= rd_y;
          ax_q     <= qx_q;
          ay_q     <= qy_q;
          bx_q     <= rd_x;
          by_q     <= rd_y;
          go_q     <= 1'b1;
          state_q  <= S_W_Q0;
        end
        S_W_Q0: begin
          if (d_done) begin
            bestd_q <= d_res;
            best_q  <= prog_q;
            end_q   <= CNT_W'(prog_q) + 1'b1;
            acc_q   <= '0;
            state_q <= S_W_CHK;
          end
        end
        S_W_CHK: begin
          state_q <= more_w ? S_W_RD : S_C_PREV;
        end
        S_W_RD: begin
          cur_x_q <= rd_x;
          cur_y_q <= rd_y;
          ax_q    <= prev_x_q;
          ay_q    <= prev_y_q;
          bx_q    <= rd_x;
          by_q    <= rd_y;
          go_q    <= 1'b1;
          state_q <= S_W_SEG;
        end
        S_W_SEG: begin
          if (d_done) begin
            acc_q   <= acc_q + ACC_W'(d_res);
            ax_q    <= qx_q;
            ay_q    <= qy_q;
            bx_q    <= cur_x_q;
            by_q    <= cur_y_q;
            go_q    <= 1'b1;
            state_q <= S_W_QD;
          end
        end
        S_W_QD: begin
          if (d_done) begin
            // strict compare keeps the earliest index on a tie
            if (d_res < bestd_q) begin
              bestd_q <= d_res;
              best_q  <= end_q[IDX_W-1:0];
            end
            prev_x_q <= cur_x_q;
            prev_y_q <= cur_y_q;
            end_q    <= end_q + 1'b1;
            state_q  <= S_W_CHK;
          end
        end
        S_C_PREV: begin
          prev_x_q <= rd_x;
          prev_y_q <= rd_y;
          end_q    <= CNT_W'(best_q) + 1'b1;
          acc_q    <= '0;
          state_q  <= S_C_CHK;
        end
        S_C_CHK: begin
          if (more_c) begin
            state_q <= S_C_RD;
          end else begin
            prog_q       <= best_q;
            res_status_q <= STATUS_OK;
            res_end_q    <= END_OUT_W'(end_q);
            state_q      <= S_OUT;
          end
        end
        S_C_RD: begin
          ax_q     <= prev_x_q;
          ay_q     <= prev_y_q;
          bx_q     <= rd_x;
          by_q     <= rd_y;
          prev_x_q <= rd_x;
          prev_y_q <= rd_y;
          go_q     <= 1'b1;
          state_q  <= S_C_SEG;
        end
        S_C_SEG: begin
          if (d_done) begin
            acc_q   <= acc_q + ACC_W'(d_res);
            end_q   <= end_q + 1'b1;
            state_q <= S_C_CHK;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_status_q;
            m_data_q  <= OUT_DATA_W'({ovf_q, res_end_q, IDX_OUT_W'(best_q)});
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

>>> src/pcs_checker.sv
module pcs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pcs_pkg::IN_USER_W-1:0]    s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pcs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input logic [pcs_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
  import pcs_pkg::*;

  // a stalled word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // an empty path gives zero index and zero corridor end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == STATUS_EMPTY |-> m_axis_tdata[20:0] == 21'd0)
    else $error("empty status with nonzero indices");

  // the corridor always holds the nearest waypoint
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] == STATUS_OK |->
      m_axis_tdata[20:10] > {1'b0, m_axis_tdata[9:0]})
    else $error("corridor end not past nearest index");

  // a new word only follows an accepted pose query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != KIND_QUERY && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result without a pose query");

endmodule

bind path_progress_corridor_search_unit pcs_checker u_pcs_checker (.*);

>>> bench/path_progress_corridor_search_unit_tb.sv
module path_progress_corridor_search_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  localparam int NPTS = 1024;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int POS_MIN = -8388608;
  localparam int POS_MAX = 8388607;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
  } pt_word_t;

  typedef struct packed {
    logic                 status;
    logic [IDX_OUT_W-1:0] idx;
    logic [END_OUT_W-1:0] cend;
    logic                 ovf;
  } track_res_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o, cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic [IN_USER_W-1:0] s_axis_tuser;
  logic m_axis_tvalid, m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  path_progress_corridor_search_unit u_dut (.*);

  // path model
  logic signed [POS_W-1:0] path_x [NPTS];
  logic signed [POS_W-1:0] path_y [NPTS];
  int unsigned path_len, progress;
  logic        dropped;
  longint unsigned corridor_mm, search_mm;

  pt_word_t   word_q [$];
  track_res_t track_q [$];
  int errors;
  longint cycles;
  bit quiet_rx;
  int hold_req, hold_served, hold_cnt, rx_wait, tx_gap;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic longint unsigned dist_mm(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx, dy, sq, r, t;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    sq = dx * dx + dy * dy;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= sq) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned seg_mm(int unsigned i);
    return dist_mm(path_x[i-1], path_y[i-1], path_x[i], path_y[i]);
  endfunction

  function automatic void track_pose(pt_word_t w);
    track_res_t r;
    int unsigned stop, best;
    longint unsigned acc, bestd, d;
    longint qx, qy;
    case (w.kind)
      KIND_NEW, KIND_APPEND: begin
        if (w.kind == KIND_NEW) begin
          path_len = 0; progress = 0; dropped = 1'b0;
        end
        if (path_len < NPTS) begin
          path_x[path_len] = w.x;
          path_y[path_len] = w.y;
          path_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_QUERY: begin
        r = '0;
        r.ovf = dropped;
        if (path_len == 0 || progress >= path_len) begin
          r.status = STATUS_EMPTY;
        end else begin
          qx = longint'($signed(w.x));
          qy = longint'($signed(w.y));
          stop = progress + 1;
          acc = 0;
          while (stop < path_len && acc < search_mm) begin
            acc += seg_mm(stop);
            stop++;
          end
          best = progress;
          bestd = dist_mm(qx, qy, path_x[best], path_y[best]);
          for (int unsigned i = progress + 1; i < stop; i++) begin
            d = dist_mm(qx, qy, path_x[i], path_y[i]);
            if (d < bestd) begin
              bestd = d; best = i;
            end
          end
          progress = best;
          stop = best + 1;
          acc = 0;
          while (stop < path_len && acc < corridor_mm) begin
            acc += seg_mm(stop);
            stop++;
          end
          r.status = STATUS_OK;
          r.idx = best[IDX_OUT_W-1:0];
          r.cend = stop[END_OUT_W-1:0];
        end
        track_q = {track_q, r};
      end
      default: ;
    endcase
  endfunction

  // sender
  always @(posedge clk_i) begin
    pt_word_t w;
    bit take;
    if (rst_ni) begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) track_pose({s_axis_tuser, s_axis_tdata[POS_W-1:0],
                            s_axis_tdata[2*POS_W-1:POS_W]});
      if (!s_axis_tvalid || take) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (word_q.size() > 0) begin
          w = word_q.pop_front();
          s_axis_tuser <= w.kind;
          s_axis_tdata <= {w.y, w.x};
          s_axis_tvalid <= 1'b1;
          tx_gap <= quiet_rx ? 0 : $urandom_range(0, 15);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk_i) begin
    int w;
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_req != hold_served) begin
        hold_served <= hold_req;
        hold_cnt <= 400;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        w = quiet_rx ? 0 : $urandom_range(0, 15);
        rx_wait <= w;
        m_axis_tready <= (w == 0);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    track_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (track_q.size() == 0) begin
        $display("%0t: unexpected result word, actual tuser %h tdata %h",
                 $time, m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        e = track_q.pop_front();
        if (m_axis_tuser[0] !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tdata[9:0] !== e.idx) begin
          $display("%0t: nearest_index expected %0d actual %0d", $time, e.idx,
                   m_axis_tdata[9:0]);
          errors++;
        end
        if (m_axis_tdata[20:10] !== e.cend) begin
          $display("%0t: corridor limit expected %0d actual %0d", $time, e.cend,
                   m_axis_tdata[20:10]);
          errors++;
        end
        if (m_axis_tdata[21] !== e.ovf) begin
          $display("%0t: overflowed expected %0d actual %0d", $time, e.ovf,
                   m_axis_tdata[21]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[path_progress_corridor_search_unit] ERROR");
      $finish;
    end
  end

  task automatic push_word(logic [KIND_W-1:0] k, int x, int y);
    pt_word_t w;
    w.kind = k;
    w.x = x[POS_W-1:0];
    w.y = y[POS_W-1:0];
    word_q = {word_q, w};
  endtask

  task automatic drain();
    while (word_q.size() > 0 || s_axis_tvalid || track_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] v);
    drain();
    cfg_index_i <= idx;
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_IDX_CORRIDOR) corridor_mm = v;
    else search_mm = v;
  endtask

  function automatic int wild_pos();
    logic [31:0] u;
    u = $urandom();
    return int'($signed(u[POS_W-1:0]));
  endfunction

  // one path of n points followed by queries walking along it, mixed with wild queries, spare-kind words and appends
  task automatic random_path(int n, int nq, int step, ref int words);
    int xs[$], ys[$];
    int cx, cy, cur;
    cx = ($urandom_range(0, 9) == 0) ? wild_pos() : int'($urandom_range(0, 20000)) - 10000;
    cy = ($urandom_range(0, 9) == 0) ? wild_pos() : int'($urandom_range(0, 20000)) - 10000;
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 19) == 0) begin
          cx = wild_pos(); cy = wild_pos();
        end else begin
          cx += int'($urandom_range(0, 2 * step)) - step;
          cy += int'($urandom_range(0, 2 * step)) - step;
          if (cx < POS_MIN || cx > POS_MAX) cx = 0;
          if (cy < POS_MIN || cy > POS_MAX) cy = 0;
        end
      end
      xs = {xs, cx};
      ys = {ys, cy};
      push_word(i == 0 ? KIND_NEW : KIND_APPEND, cx, cy);
      words++;
    end
    cur = 0;
    for (int q = 0; q < nq; q++) begin
      cur += $urandom_range(0, 3);
      if (cur >= n) cur = n - 1;
      case ($urandom_range(0, 9))
        0: push_word(KIND_QUERY, wild_pos(), wild_pos());
        1: push_word(KIND_SPARE, wild_pos(), wild_pos());
        2: begin
          push_word(KIND_APPEND, cx + 50, cy - 50);
          words++;
        end
        default: push_word(KIND_QUERY, xs[cur] + int'($urandom_range(0, 200)) - 100,
                           ys[cur] + int'($urandom_range(0, 200)) - 100);
      endcase
      words++;
    end
  endtask

  initial begin
    int words, ph;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = CFG_IDX_CORRIDOR; cfg_data_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = KIND_NEW;
    m_axis_tready = 1'b0;
    path_len = 0; progress = 0; dropped = 1'b0;
    corridor_mm = RST_CORRIDOR_MM; search_mm = RST_SEARCH_MM;
    errors = 0; cycles = 0; quiet_rx = 1'b0;
    hold_req = 0; hold_served = 0; hold_cnt = 0; rx_wait = 0; tx_gap = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty path, ignored kind, append with no start, extremes, tie
    push_word(KIND_QUERY, 0, 0);
    push_word(KIND_SPARE, POS_MAX, POS_MIN);
    push_word(KIND_APPEND, POS_MAX, POS_MIN);
    push_word(KIND_APPEND, POS_MIN, POS_MAX);
    push_word(KIND_QUERY, POS_MIN, POS_MAX);
    push_word(KIND_QUERY, POS_MAX, POS_MAX);
    push_word(KIND_NEW, 0, 0);
    push_word(KIND_APPEND, 100, 0);
    push_word(KIND_APPEND, 1000, 0);
    push_word(KIND_APPEND, 1000, 1000);
    push_word(KIND_QUERY, 50, 0);
    push_word(KIND_QUERY, 1000, 10);
    write_reg(CFG_IDX_SEARCH, '0);
    write_reg(CFG_IDX_CORRIDOR, '0);
    push_word(KIND_NEW, -5, -5);
    push_word(KIND_APPEND, 5, 5);
    push_word(KIND_APPEND, 15, 15);
    push_word(KIND_QUERY, 15, 15);
    write_reg(CFG_IDX_SEARCH, 24'hFFFFFF);
    write_reg(CFG_IDX_CORRIDOR, 24'hFFFFFF);
    push_word(KIND_QUERY, 15, 15);
    push_word(KIND_QUERY, POS_MIN, POS_MIN);

    // overflow: fill the store past capacity
    write_reg(CFG_IDX_SEARCH, 24'd60);
    write_reg(CFG_IDX_CORRIDOR, 24'd100);
    quiet_rx = 1'b1;
    push_word(KIND_NEW, 0, 0);
    for (int i = 1; i < NPTS + 6; i++) push_word(KIND_APPEND, 10 * i, 0);
    for (int i = 0; i < 6; i++) push_word(KIND_QUERY, 25 * i + 7, 3);
    drain();
    quiet_rx = 1'b0;
    write_reg(CFG_IDX_CORRIDOR, 24'hFFFFFF);
    push_word(KIND_QUERY, 200, 0);
    write_reg(CFG_IDX_SEARCH, 24'hFFFFFF);
    write_reg(CFG_IDX_CORRIDOR, 24'd0);
    push_word(KIND_QUERY, 10230, 0);

    // random phases under varied settings
    words = 0;
    ph = 0;
    while (words < 700) begin
      case (ph % 5)
        0: begin
          write_reg(CFG_IDX_CORRIDOR, CFG_W'($urandom_range(0, 3000)));
          write_reg(CFG_IDX_SEARCH, CFG_W'($urandom_range(0, 4000)));
        end
        1: begin
          write_reg(CFG_IDX_CORRIDOR, '0);
          write_reg(CFG_IDX_SEARCH, 24'hFFFFFF);
        end
        2: begin
          write_reg(CFG_IDX_CORRIDOR, 24'hFFFFFF);
          write_reg(CFG_IDX_SEARCH, '0);
        end
        3: begin
          write_reg(CFG_IDX_CORRIDOR, CFG_W'($urandom()));
          write_reg(CFG_IDX_SEARCH, CFG_W'($urandom_range(200, 1500)));
        end
        default: begin
          write_reg(CFG_IDX_CORRIDOR, RST_CORRIDOR_MM);
          write_reg(CFG_IDX_SEARCH, RST_SEARCH_MM);
        end
      endcase
      quiet_rx = (ph % 4 == 3);
      if (ph == 2) hold_req++;
      for (int p = 0; p < 4; p++)
        random_path($urandom_range(1, 24), $urandom_range(2, 12), $urandom_range(5, 800), words);
      ph++;
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("[path_progress_corridor_search_unit] OK");
    end else begin
      $display("[path_progress_corridor_search_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/pcs_pkg.sv
src/pcs_ram.sv
src/pcs_dist.sv
src/path_progress_corridor_search_unit.sv
src/pcs_checker.sv
bench/path_progress_corridor_search_unit_tb.sv
